@@ hdl/pixel_grayscale_sepia_filter_defines.svh @@
// Assertion macros for the pixel grayscale / sepia filter.
// No dependencies; included by the top level.
`ifndef PIXEL_GRAYSCALE_SEPIA_FILTER_DEFINES_SVH
`define PIXEL_GRAYSCALE_SEPIA_FILTER_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define PGSF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgsf assertion failed");

// next-cycle implication, checked on clk_i, off during reset
`define PGSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgsf assertion failed");

`endif

@@ hdl/pgsf_pkg.sv @@
// Types and constants for the pixel grayscale / sepia filter.
// No dependencies.
`timescale 1ns / 1ps
package pgsf_pkg;

  typedef struct packed {
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] filter_status;
  } result_t;

  typedef logic [9:0] coef_t;

  localparam int unsigned MaxDim = 4096;

  // register indexes
  localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [2:0] REG_IMAGE_LOADED = 3'd1;
  localparam logic [2:0] REG_COLOR_IMAGE  = 3'd2;
  localparam logic [2:0] REG_SEL_X_START  = 3'd3;
  localparam logic [2:0] REG_SEL_Y_START  = 3'd4;
  localparam logic [2:0] REG_SEL_X_END    = 3'd5;
  localparam logic [2:0] REG_SEL_Y_END    = 3'd6;

  // status codes
  localparam logic [1:0] ST_FILTERED = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_GREY     = 2'd2;
  localparam logic [1:0] ST_NO_IMAGE = 2'd3;

  localparam logic MODE_GRAY  = 1'b0;
  localparam logic MODE_SEPIA = 1'b1;

  // sepia matrix in thousandths, [out channel][r g b]
  localparam coef_t SepiaCoef [3][3] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  localparam logic [18:0] SepiaRound    = 19'd500;
  localparam logic [18:0] SepiaSatLimit = 19'd256000;  // x/1000 >= 256
  // ceil(2^28/1000): exact floor(x/1000) for x < 2^18
  localparam logic [18:0] SepiaRecip    = 19'd268436;
  localparam int unsigned SepiaShift    = 28;
  // ceil(2^12/3): exact floor(x/3) for x < 2^10
  localparam logic [10:0] GrayRecip     = 11'd1366;
  localparam int unsigned GrayShift     = 12;

endpackage

@@ hdl/pixel_grayscale_sepia_filter.sv @@
// Pixel grayscale / sepia filter. An accepted start is carried by valid_q and
// out_valid_q to the strobe. One pixel per cycle; busy stays low, and the
// sepia path (product, sum, reciprocal multiply stages) sets the depth.
// Reset clears the configuration to its defaults and empties the pipeline.
// Results are strobed for one cycle; the receiver cannot stall.
// Depends on pgsf_pkg, pgsf_sepia and the defines header.
`timescale 1ns / 1ps
`include "pixel_grayscale_sepia_filter_defines.svh"
module pixel_grayscale_sepia_filter import pgsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  // configuration
  logic        filter_mode_q;
  logic        image_loaded_q;
  logic        color_image_q;
  logic [11:0] sel_x_start_q;
  logic [11:0] sel_y_start_q;
  logic [12:0] sel_x_end_q;
  logic [12:0] sel_y_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q  <= MODE_GRAY;
      image_loaded_q <= 1'b0;
      color_image_q  <= 1'b0;
      sel_x_start_q  <= 12'd0;
      sel_y_start_q  <= 12'd0;
      sel_x_end_q    <= 13'd4096;
      sel_y_end_q    <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FILTER_MODE:  filter_mode_q  <= cfg_wdata_i[0];
        REG_IMAGE_LOADED: image_loaded_q <= cfg_wdata_i[0];
        REG_COLOR_IMAGE:  color_image_q  <= cfg_wdata_i[0];
        REG_SEL_X_START:  sel_x_start_q  <= cfg_wdata_i[11:0];
        REG_SEL_Y_START:  sel_y_start_q  <= cfg_wdata_i[11:0];
        REG_SEL_X_END:    sel_x_end_q    <= cfg_wdata_i;
        REG_SEL_Y_END:    sel_y_end_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // status decode on the incoming item
  logic       in_sel;
  logic [1:0] status_d;

  always_comb begin
    in_sel = (32'(pixel_i.pixel_row) < MaxDim) && (32'(pixel_i.pixel_col) < MaxDim) &&
             (pixel_i.pixel_col >= sel_x_start_q) &&
             ({1'b0, pixel_i.pixel_col} < sel_x_end_q) &&
             (pixel_i.pixel_row >= sel_y_start_q) &&
             ({1'b0, pixel_i.pixel_row} < sel_y_end_q);
    if (!image_loaded_q) begin
      status_d = ST_NO_IMAGE;
    end else if (!color_image_q) begin
      status_d = ST_GREY;
    end else if (!in_sel) begin
      status_d = ST_OUTSIDE;
    end else begin
      status_d = ST_FILTERED;
    end
  end

  // control and pass-through, three stages alongside the datapath
  logic [2:0] valid_q;
  logic [1:0] status_q [3];
  logic       mode_q   [3];
  logic [7:0] pass_q   [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    status_q[0]  <= status_d;
    mode_q[0]    <= filter_mode_q;
    pass_q[0][0] <= pixel_i.red_in;
    pass_q[0][1] <= pixel_i.green_in;
    pass_q[0][2] <= pixel_i.blue_in;
    for (int s = 1; s < 3; s++) begin
      status_q[s] <= status_q[s-1];
      mode_q[s]   <= mode_q[s-1];
      pass_q[s]   <= pass_q[s-1];
    end
  end

  // grayscale path: sum, reciprocal multiply, shift
  logic [9:0]  gsum_q;
  logic [20:0] gprod_q;
  logic [7:0]  gavg_q;

  always_ff @(posedge clk_i) begin
    gsum_q  <= 10'(pixel_i.red_in) + 10'(pixel_i.green_in) + 10'(pixel_i.blue_in) + 10'd1;
    gprod_q <= 21'(gsum_q) * 21'(GrayRecip);
    gavg_q  <= gprod_q[GrayShift +: 8];
  end

  logic [7:0] sep [3];

  pgsf_sepia u_sepia (
    .clk_i   (clk_i),
    .red_i   (pixel_i.red_in),
    .green_i (pixel_i.green_in),
    .blue_i  (pixel_i.blue_in),
    .sep_o   (sep)
  );

  // output stage
  result_t result_d;
  logic    out_valid_q;
  result_t result_q;

  always_comb begin
    result_d.filter_status = status_q[2];
    if (status_q[2] != ST_FILTERED) begin
      result_d.red_out   = pass_q[2][0];
      result_d.green_out = pass_q[2][1];
      result_d.blue_out  = pass_q[2][2];
    end else if (mode_q[2] == MODE_SEPIA) begin
      result_d.red_out   = sep[0];
      result_d.green_out = sep[1];
      result_d.blue_out  = sep[2];
    end else begin
      result_d.red_out   = gavg_q;
      result_d.green_out = gavg_q;
      result_d.blue_out  = gavg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = result_q;

  logic gray_out;
  logic gray_same;
  logic passed_out;
  assign gray_out = valid_q[2] && (status_q[2] == ST_FILTERED) && (mode_q[2] == MODE_GRAY);
  assign gray_same = (result_o.red_out == result_o.green_out) &&
                     (result_o.green_out == result_o.blue_out);
  assign passed_out = result_valid_o && (result_o.filter_status != ST_FILTERED);

  `PGSF_ASSERT_IMPL(a_latency, accept, ##4 result_valid_o)
  `PGSF_ASSERT_NEXT(a_gray_equal, gray_out, gray_same)
  `PGSF_ASSERT_IMPL(a_pass_red, passed_out, result_o.red_out == $past(pixel_i.red_in, 4))

endmodule

@@ hdl/pgsf_sepia.sv @@
// Three-stage sepia datapath: products, rounded sums, reciprocal divide by 1000.
// Depends on pgsf_pkg. Output is combinational from the third register stage.
`timescale 1ns / 1ps
module pgsf_sepia import pgsf_pkg::*; (
  input  logic       clk_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic [7:0] sep_o [3]
);

  logic [17:0] prod_d [3][3];
  logic [17:0] prod_q [3][3];
  logic [18:0] acc_d  [3];
  logic [18:0] acc_q  [3];
  logic [36:0] quot_d [3];
  logic [36:0] quot_q [3];
  logic        sat_d  [3];
  logic        sat_q  [3];
  logic [7:0]  chan   [3];

  always_comb begin
    chan[0] = red_i;
    chan[1] = green_i;
    chan[2] = blue_i;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[c][k] = 18'(chan[k]) * 18'(SepiaCoef[c][k]);
      end
      acc_d[c] = 19'(prod_q[c][0]) + 19'(prod_q[c][1]) + 19'(prod_q[c][2]) + SepiaRound;
      sat_d[c] = acc_q[c] >= SepiaSatLimit;
      // below the saturation limit the value fits in 18 bits
      quot_d[c] = 37'(acc_q[c][17:0]) * 37'(SepiaRecip);
      sep_o[c] = sat_q[c] ? 8'hFF : quot_q[c][SepiaShift +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for pixel_grayscale_sepia_filter: a directed table,
// then randomized setups and pixel streams with random start gaps.
// Depends on pgsf_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb_top import pgsf_pkg::*; ();

  typedef struct packed {
    logic        mode;
    logic        loaded;
    logic        color;
    logic [11:0] x_start;
    logic [11:0] y_start;
    logic [12:0] x_end;
    logic [12:0] y_end;
  } filter_cfg_t;

  typedef struct packed {
    logic [2:0] cfg_sel;  // index into DirSetups
    pixel_t     px;
    logic       typed;    // result below is known up front
    result_t    want;
  } dir_row_t;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandPhases = 13;
  localparam int unsigned ItemsPerPhase = 100;

  localparam filter_cfg_t DirSetups [7] = '{
    '{MODE_GRAY,  1'b0, 1'b0, 12'd0,    12'd0,    13'd4096, 13'd4096},
    '{MODE_GRAY,  1'b1, 1'b0, 12'd0,    12'd0,    13'd4096, 13'd4096},
    '{MODE_GRAY,  1'b1, 1'b1, 12'd0,    12'd0,    13'd4096, 13'd4096},
    '{MODE_SEPIA, 1'b1, 1'b1, 12'd0,    12'd0,    13'd4096, 13'd4096},
    '{MODE_SEPIA, 1'b1, 1'b1, 12'd100,  12'd50,   13'd200,  13'd60},
    '{MODE_GRAY,  1'b1, 1'b1, 12'd4095, 12'd4095, 13'd8191, 13'd8191},
    '{MODE_SEPIA, 1'b1, 1'b1, 12'd300,  12'd0,    13'd300,  13'd0}
  };

  localparam dir_row_t DirRows [23] = '{
    // no image: pass through
    '{3'd0, '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095}, 1'b1,
      '{8'd255, 8'd255, 8'd255, ST_NO_IMAGE}},
    '{3'd0, '{8'd0, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, ST_NO_IMAGE}},
    '{3'd0, '{8'd18, 8'd52, 8'd86, 12'd7, 12'd9}, 1'b1,
      '{8'd18, 8'd52, 8'd86, ST_NO_IMAGE}},
    // grey image: filters unavailable
    '{3'd1, '{8'd255, 8'd0, 8'd255, 12'd0, 12'd4095}, 1'b1,
      '{8'd255, 8'd0, 8'd255, ST_GREY}},
    '{3'd1, '{8'd0, 8'd255, 8'd0, 12'd4095, 12'd0}, 1'b1, '{8'd0, 8'd255, 8'd0, ST_GREY}},
    // average grayscale
    '{3'd2, '{8'd0, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, ST_FILTERED}},
    '{3'd2, '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095}, 1'b1,
      '{8'd255, 8'd255, 8'd255, ST_FILTERED}},
    '{3'd2, '{8'd1, 8'd0, 8'd0, 12'd3, 12'd4}, 1'b0, '0},
    '{3'd2, '{8'd1, 8'd1, 8'd0, 12'd3, 12'd4}, 1'b0, '0},
    '{3'd2, '{8'd200, 8'd100, 8'd50, 12'd11, 12'd12}, 1'b0, '0},
    // sepia, blue does not saturate for white
    '{3'd3, '{8'd255, 8'd255, 8'd255, 12'd5, 12'd5}, 1'b1,
      '{8'd255, 8'd255, 8'd239, ST_FILTERED}},
    '{3'd3, '{8'd0, 8'd0, 8'd0, 12'd5, 12'd5}, 1'b1, '{8'd0, 8'd0, 8'd0, ST_FILTERED}},
    '{3'd3, '{8'd1, 8'd1, 8'd1, 12'd5, 12'd5}, 1'b0, '0},
    '{3'd3, '{8'd100, 8'd50, 8'd25, 12'd5, 12'd5}, 1'b0, '0},
    '{3'd3, '{8'd0, 8'd0, 8'd255, 12'd5, 12'd5}, 1'b0, '0},
    // window corners, then just outside the x start, x end and y start edges
    '{3'd4, '{8'd90, 8'd80, 8'd70, 12'd50, 12'd100}, 1'b0, '0},
    '{3'd4, '{8'd90, 8'd80, 8'd70, 12'd59, 12'd199}, 1'b0, '0},
    '{3'd4, '{8'd90, 8'd80, 8'd70, 12'd50, 12'd99}, 1'b1, '{8'd90, 8'd80, 8'd70, ST_OUTSIDE}},
    '{3'd4, '{8'd90, 8'd80, 8'd70, 12'd55, 12'd200}, 1'b1, '{8'd90, 8'd80, 8'd70, ST_OUTSIDE}},
    '{3'd4, '{8'd90, 8'd80, 8'd70, 12'd49, 12'd150}, 1'b1, '{8'd90, 8'd80, 8'd70, ST_OUTSIDE}},
    // ends past the image edge
    '{3'd5, '{8'd40, 8'd30, 8'd20, 12'd4095, 12'd4095}, 1'b0, '0},
    '{3'd5, '{8'd40, 8'd30, 8'd20, 12'd4095, 12'd4094}, 1'b1,
      '{8'd40, 8'd30, 8'd20, ST_OUTSIDE}},
    // empty selection
    '{3'd6, '{8'd40, 8'd30, 8'd20, 12'd10, 12'd300}, 1'b1, '{8'd40, 8'd30, 8'd20, ST_OUTSIDE}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pixel_t      pixel_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [12:0] cfg_wdata_i;
  logic        result_valid_o;
  result_t     result_o;

  // expectation sideband, driven along with the item
  logic        row_typed;
  result_t     row_want;

  filter_cfg_t cur_cfg;
  result_t     pending_results[$];
  int unsigned n_errors;
  int unsigned idle_cycles;

  pixel_grayscale_sepia_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] sepia_tone(pixel_t px, int unsigned kr, int unsigned kg,
                                            int unsigned kb);
    int unsigned acc;
    int unsigned v;
    acc = kr * px.red_in + kg * px.green_in + kb * px.blue_in;
    v = (acc + 500) / 1000;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic result_t filter_pixel(pixel_t px, filter_cfg_t c);
    result_t     res;
    logic        in_sel;
    int unsigned avg;
    res = '{px.red_in, px.green_in, px.blue_in, ST_FILTERED};
    in_sel = px.pixel_col >= c.x_start && px.pixel_col < c.x_end &&
             px.pixel_row >= c.y_start && px.pixel_row < c.y_end;
    if (!c.loaded) begin
      res.filter_status = ST_NO_IMAGE;
    end else if (!c.color) begin
      res.filter_status = ST_GREY;
    end else if (!in_sel) begin
      res.filter_status = ST_OUTSIDE;
    end else if (c.mode == MODE_GRAY) begin
      avg = (px.red_in + px.green_in + px.blue_in + 1) / 3;
      res.red_out = 8'(avg);
      res.green_out = 8'(avg);
      res.blue_out = 8'(avg);
    end else begin
      res.red_out = sepia_tone(px, 393, 769, 189);
      res.green_out = sepia_tone(px, 349, 686, 168);
      res.blue_out = sepia_tone(px, 272, 534, 131);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    n_errors++;
    if (n_errors <= 100)
      $display("mismatch %s: expected %0d got %0d at %0t ns", what, want_v, got_v, $time);
  endtask

  // checks results against the oldest expectation, then records new items
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item pending", -1, result_o.filter_status);
        end else begin
          want = pending_results.pop_front();
          if (result_o.red_out !== want.red_out)
            report_mismatch("red_out", want.red_out, result_o.red_out);
          if (result_o.green_out !== want.green_out)
            report_mismatch("green_out", want.green_out, result_o.green_out);
          if (result_o.blue_out !== want.blue_out)
            report_mismatch("blue_out", want.blue_out, result_o.blue_out);
          if (result_o.filter_status !== want.filter_status)
            report_mismatch("filter_status", want.filter_status, result_o.filter_status);
        end
      end
      if (start && !busy)
        pending_results.push_back(row_typed ? row_want : filter_pixel(pixel_i, cur_cfg));
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("** pixel_grayscale_sepia_filter: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_pixel(input pixel_t px, input logic typed, input result_t want,
                            input int unsigned gap);
    start <= 1'b1;
    pixel_i <= px;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // waits for the pipeline to empty, then writes every register
  task automatic load_setup(input filter_cfg_t c);
    logic [2:0]  idx [7];
    logic [12:0] val [7];
    logic [12:0] mask [7];
    idx = '{REG_FILTER_MODE, REG_IMAGE_LOADED, REG_COLOR_IMAGE, REG_SEL_X_START,
            REG_SEL_Y_START, REG_SEL_X_END, REG_SEL_Y_END};
    val = '{13'(c.mode), 13'(c.loaded), 13'(c.color), 13'(c.x_start), 13'(c.y_start),
            c.x_end, c.y_end};
    mask = '{13'h1, 13'h1, 13'h1, 13'hfff, 13'hfff, 13'h1fff, 13'h1fff};
    start <= 1'b0;
    // let an item taken at the last edge reach the queue first
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      // junk above the register width must be ignored
      cfg_wdata_i <= (13'($urandom) & ~mask[i]) | val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic logic [12:0] pick_end();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4095;
      3: return 13'd4096;
      4: return 13'd4097;
      default: return 13'd8191;
    endcase
  endfunction

  function automatic filter_cfg_t random_setup();
    filter_cfg_t c;
    c.mode = 1'($urandom_range(0, 1));
    c.loaded = ($urandom_range(0, 9) != 0);
    c.color = ($urandom_range(0, 9) != 0);
    c.x_start = '0;
    c.y_start = '0;
    c.x_end = 13'd4096;
    c.y_end = 13'd4096;
    case ($urandom_range(0, 5))
      0: ;  // whole image
      1: begin
        c.x_start = 12'($urandom_range(0, 4095));
        c.y_start = 12'($urandom_range(0, 4095));
        c.x_end = c.x_start + 13'($urandom_range(1, 4096 - c.x_start));
        c.y_end = c.y_start + 13'($urandom_range(1, 4096 - c.y_start));
      end
      2: begin
        c.x_start = 12'($urandom_range(0, 4000));
        c.y_start = 12'($urandom_range(0, 4000));
        c.x_end = c.x_start + 13'($urandom_range(1, 16));
        c.y_end = c.y_start + 13'($urandom_range(1, 16));
      end
      3: begin  // start not below end
        c.x_end = 13'($urandom_range(0, 4095));
        c.x_start = 12'($urandom_range(c.x_end, 4095));
      end
      4: begin
        c.x_start = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        c.y_start = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        c.x_end = pick_end();
        c.y_end = pick_end();
      end
      default: begin
        c.x_start = 12'($urandom);
        c.y_start = 12'($urandom);
        c.x_end = 13'($urandom);
        c.y_end = 13'($urandom);
      end
    endcase
    return c;
  endfunction

  // half the time hugs the selection edges
  function automatic logic [11:0] pick_coord(logic [11:0] first, logic [12:0] last);
    case ($urandom_range(0, 7))
      0: return first - 12'd1;
      1: return first;
      2: return 12'(last - 13'd1);
      3: return 12'(last);
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    filter_cfg_t setup;
    pixel_t      px;
    logic [2:0]  cur_sel;
    logic        burst;
    rst_ni <= 1'b0;
    start <= 1'b0;
    pixel_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_FILTER_MODE;
    cfg_wdata_i <= '0;
    row_typed <= 1'b0;
    row_want <= '0;
    n_errors = 0;
    cur_cfg = DirSetups[0];  // reset values
    cur_sel = 3'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].cfg_sel != cur_sel) begin
        cur_sel = DirRows[i].cfg_sel;
        load_setup(DirSetups[cur_sel]);
      end
      send_pixel(DirRows[i].px, DirRows[i].typed, DirRows[i].want, pick_gap());
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      setup = random_setup();
      load_setup(setup);
      burst = ($urandom_range(0, 3) == 0);
      repeat (ItemsPerPhase) begin
        px.red_in = pick_channel();
        px.green_in = pick_channel();
        px.blue_in = pick_channel();
        px.pixel_row = pick_coord(setup.y_start, setup.y_end);
        px.pixel_col = pick_coord(setup.x_start, setup.x_end);
        send_pixel(px, 1'b0, '0, burst ? 0 : pick_gap());
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("items left without result", 0, pending_results.size());
    if (n_errors == 0) begin
      $display("** pixel_grayscale_sepia_filter: PASSED **");
    end else begin
      $display("** pixel_grayscale_sepia_filter: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/pgsf_pkg.sv
hdl/pgsf_sepia.sv
hdl/pixel_grayscale_sepia_filter.sv
tb/tb_top.sv
